/* rtl/core/swrs_pkg.sv */
`default_nettype none

package swrs_pkg;

  localparam int DEPTH = 16;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int ACT_W = 3;
  localparam int STAT_W = 2;
  localparam int HELD_W = 5;
  localparam int CAP_W = 5;
  // common width for count / capacity compares
  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_REVERSE = 3'd3,
    ACT_SORT    = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WALK
  } core_state_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_RD0,
    W_RD1,
    W_CMP,
    W_WR1
  } walk_state_t;

  typedef struct packed {
    logic          start;
    logic          sort;
    logic [CW-1:0] count;
  } walk_cmd_t;

  typedef struct packed {
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
  } ram_req_t;

endpackage

`default_nettype wire

/* rtl/core/swrs_in_if.sv */
`default_nettype none

interface swrs_in_if;
  logic                                valid;
  logic                                ready;
  logic [swrs_pkg::ACT_W-1:0]          action;
  logic signed [swrs_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink (input valid, input action, input push_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/swrs_out_if.sv */
`default_nettype none

interface swrs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [swrs_pkg::WORD_W-1:0]  read_value;
  logic [swrs_pkg::STAT_W-1:0]         status;
  logic [swrs_pkg::HELD_W-1:0]         entries_held;

  modport source (output valid, output read_value, output status, output entries_held,
                  input ready);
  modport sink (input valid, input read_value, input status, input entries_held,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/stack_with_reverse_and_sort_core.sv */
// Push, empty pop or peek, and no-op requests: result loads in the cycle after accept.
// Pop and peek on a held word: result loads from the S_READ state (one registered store read).
// Reverse of n words swaps floor(n/2) pairs; sort takes up to n passes over n-1 adjacent pairs,
// one pair at a time through the single compare unit and the one store read port.
// One request in flight; the next is taken once the core is idle and the result slot is free.
// Reset (rst, synchronous): empties the stack, capacity returns to 16, the result slot clears.
`default_nettype none

module stack_with_reverse_and_sort_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  swrs_in_if.sink                             req,
  swrs_out_if.source                          rsp,
  input  wire logic                           cfg_we,
  input  wire logic [swrs_pkg::CAP_W-1:0]     cfg_data
);

  swrs_pkg::core_state_t        state, state_next;
  logic [swrs_pkg::CW-1:0]      count;
  logic [swrs_pkg::CAP_W-1:0]   cap;
  logic                         is_pop;

  logic                         rsp_valid;
  logic [swrs_pkg::WORD_W-1:0]  rsp_value;
  swrs_pkg::status_t            rsp_status;
  logic [swrs_pkg::HELD_W-1:0]  rsp_held;

  logic                         accept;
  logic                         slot_free;
  logic [swrs_pkg::MW-1:0]      cap_eff;
  logic                         full;
  logic                         empty;
  logic                         many;
  logic                         is_push, is_read, is_walk;
  logic                         push_ok;
  logic                         load_now;

  swrs_pkg::walk_cmd_t          walk_cmd;
  swrs_pkg::ram_req_t           walk_ram;
  swrs_pkg::ram_req_t           ram;
  logic                         walk_done;
  logic [swrs_pkg::WORD_W-1:0]  rd_data;

  // Effective capacity saturates at the store depth
  assign cap_eff = (swrs_pkg::MW'(cap) > swrs_pkg::MW'(swrs_pkg::DEPTH))
                 ? swrs_pkg::MW'(swrs_pkg::DEPTH) : swrs_pkg::MW'(cap);
  assign full  = swrs_pkg::MW'(count) >= cap_eff;
  assign empty = (count == '0);
  assign many  = (count > swrs_pkg::CW'(1));

  assign is_push = (req.action == swrs_pkg::ACT_PUSH);
  assign is_read = (req.action == swrs_pkg::ACT_POP) || (req.action == swrs_pkg::ACT_PEEK);
  assign is_walk = (req.action == swrs_pkg::ACT_REVERSE) || (req.action == swrs_pkg::ACT_SORT);

  // Result slot frees when its current word is taken this cycle
  assign slot_free = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign push_ok   = accept && is_push && !full;

  // Requests that finish on the accept edge: push, empty reads, short walks, unknown actions
  assign load_now = accept && !(is_read && !empty) && !(is_walk && many);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      swrs_pkg::S_IDLE: begin
        if (accept && is_read && !empty) begin
          state_next = swrs_pkg::S_READ;
        end else if (accept && is_walk && many) begin
          state_next = swrs_pkg::S_WALK;
        end
      end
      swrs_pkg::S_READ: state_next = swrs_pkg::S_IDLE;
      swrs_pkg::S_WALK: begin
        if (walk_done) begin
          state_next = swrs_pkg::S_IDLE;
        end
      end
      default: state_next = swrs_pkg::S_IDLE;
    endcase
  end

  // Control outputs and store port steering
  always_comb begin
    req.ready      = 1'b0;
    walk_cmd.start = 1'b0;
    walk_cmd.sort  = (req.action == swrs_pkg::ACT_SORT);
    walk_cmd.count = count;
    // In idle, keep the top word addressed so a pop has it in the read register in the next cycle
    ram.rd_addr    = swrs_pkg::AW'(count - swrs_pkg::CW'(1));
    ram.wr_en      = 1'b0;
    ram.wr_addr    = swrs_pkg::AW'(count);
    ram.wr_data    = req.push_value;
    case (state)
      swrs_pkg::S_IDLE: begin
        req.ready      = slot_free;
        walk_cmd.start = accept && is_walk && many;
        ram.wr_en      = push_ok;
      end
      swrs_pkg::S_WALK: ram = walk_ram;
      default: ram.wr_en = 1'b0;
    endcase
  end

  swrs_ram #(
    .WIDTH (swrs_pkg::WORD_W),
    .DEPTH (swrs_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram.wr_en),
    .wr_addr (ram.wr_addr),
    .wr_data (ram.wr_data),
    .rd_addr (ram.rd_addr),
    .rd_data (rd_data)
  );

  swrs_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .cmd     (walk_cmd),
    .rd_data (rd_data),
    .ram     (walk_ram),
    .done    (walk_done)
  );

  // Control registers: state, count, capacity, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swrs_pkg::S_IDLE;
      count     <= '0;
      cap       <= swrs_pkg::CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cap <= cfg_data;
      end
      if (push_ok) begin
        count <= count + swrs_pkg::CW'(1);
      end else if ((state == swrs_pkg::S_READ) && is_pop) begin
        count <= count - swrs_pkg::CW'(1);
      end
      if (load_now || (state == swrs_pkg::S_READ) || walk_done) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold until the next load
  always_ff @(posedge clk) begin
    if (accept) begin
      is_pop <= (req.action == swrs_pkg::ACT_POP);
    end
    if (load_now) begin
      if (is_push) begin
        rsp_value <= '0;
        if (full) begin
          rsp_status <= swrs_pkg::ST_OVERFLOW;
          rsp_held   <= swrs_pkg::HELD_W'(count);
        end else begin
          rsp_status <= swrs_pkg::ST_OK;
          rsp_held   <= swrs_pkg::HELD_W'(count + swrs_pkg::CW'(1));
        end
      end else if (is_read) begin
        rsp_value  <= swrs_pkg::EMPTY_WORD;
        rsp_status <= swrs_pkg::ST_UNDERFLOW;
        rsp_held   <= swrs_pkg::HELD_W'(count);
      end else begin
        rsp_value  <= '0;
        rsp_status <= swrs_pkg::ST_OK;
        rsp_held   <= swrs_pkg::HELD_W'(count);
      end
    end else if (state == swrs_pkg::S_READ) begin
      rsp_value  <= rd_data;
      rsp_status <= swrs_pkg::ST_OK;
      rsp_held   <= is_pop ? swrs_pkg::HELD_W'(count - swrs_pkg::CW'(1))
                           : swrs_pkg::HELD_W'(count);
    end else if (walk_done) begin
      rsp_value  <= '0;
      rsp_status <= swrs_pkg::ST_OK;
      rsp_held   <= swrs_pkg::HELD_W'(count);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.read_value   = rsp_value;
  assign rsp.status       = rsp_status;
  assign rsp.entries_held = rsp_held;

`ifndef SYNTH
  // Count never runs past the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    swrs_pkg::MW'(count) <= swrs_pkg::MW'(swrs_pkg::DEPTH))
    else $error("entry count above store depth");

  // Every accepted request either has its result loaded or keeps the core busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp_valid || (state != swrs_pkg::S_IDLE)))
    else $error("accepted request left no result and no work");

  // Walker finishes only while the core waits on it
  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    walk_done |-> (state == swrs_pkg::S_WALK))
    else $error("walker done outside walk state");

  // A pop of a held word lowers the count by one when the core leaves the S_READ state
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.action == swrs_pkg::ACT_POP) && !empty)
      |=> ##1 (count == $past(count, 2) - swrs_pkg::CW'(1)))
    else $error("pop did not lower the count");
`endif

endmodule

`default_nettype wire

/* rtl/core/swrs_ram.sv */
`default_nettype none

module swrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/core/swrs_walker.sv */
`default_nettype none

// Pair walker: visits address pairs (lo, hi), reads both, and writes them
// back swapped. Reverse swaps every pair moving inward; sort runs bubble
// passes over adjacent pairs, swapping when the lower slot holds the smaller
// word, until a pass makes no swap.
module swrs_walker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire swrs_pkg::walk_cmd_t           cmd,
  input  wire logic [swrs_pkg::WORD_W-1:0]   rd_data,
  output      swrs_pkg::ram_req_t            ram,
  output      logic                          done
);

  swrs_pkg::walk_state_t         state, state_next;
  logic                          sort, sort_next;
  logic [swrs_pkg::AW-1:0]       lo, lo_next;
  logic [swrs_pkg::AW-1:0]       hi, hi_next;
  logic [swrs_pkg::AW-1:0]       last, last_next;
  logic                          swapped, swapped_next;
  logic [swrs_pkg::WORD_W-1:0]   word_a;
  logic                          do_swap;
  logic                          pair_end;
  logic                          finish;

  // shared compare: swap when the lower slot is smaller (signed)
  assign do_swap = !sort || ($signed(word_a) < $signed(rd_data));

  assign pair_end = ((state == swrs_pkg::W_CMP) && !do_swap) || (state == swrs_pkg::W_WR1);

  always_comb begin
    if (sort) begin
      finish = (hi == last) && !swapped;
    end else begin
      finish = ((hi - lo) <= swrs_pkg::AW'(2));
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    sort_next    = sort;
    lo_next      = lo;
    hi_next      = hi;
    last_next    = last;
    swapped_next = swapped;
    case (state)
      swrs_pkg::W_IDLE: begin
        if (cmd.start) begin
          sort_next    = cmd.sort;
          last_next    = swrs_pkg::AW'(cmd.count - swrs_pkg::CW'(1));
          lo_next      = '0;
          hi_next      = cmd.sort ? swrs_pkg::AW'(1)
                                  : swrs_pkg::AW'(cmd.count - swrs_pkg::CW'(1));
          swapped_next = 1'b0;
          state_next   = swrs_pkg::W_RD0;
        end
      end
      swrs_pkg::W_RD0: state_next = swrs_pkg::W_RD1;
      swrs_pkg::W_RD1: state_next = swrs_pkg::W_CMP;
      swrs_pkg::W_CMP: begin
        if (do_swap) begin
          state_next = swrs_pkg::W_WR1;
          if (sort) begin
            swapped_next = 1'b1;
          end
        end
      end
      swrs_pkg::W_WR1: state_next = swrs_pkg::W_RD0;
      default: state_next = swrs_pkg::W_IDLE;
    endcase

    if (pair_end) begin
      if (finish) begin
        state_next = swrs_pkg::W_IDLE;
      end else begin
        state_next = swrs_pkg::W_RD0;
        if (sort) begin
          if (hi == last) begin
            // start another pass
            lo_next      = '0;
            hi_next      = swrs_pkg::AW'(1);
            swapped_next = 1'b0;
          end else begin
            lo_next = lo + swrs_pkg::AW'(1);
            hi_next = hi + swrs_pkg::AW'(1);
          end
        end else begin
          lo_next = lo + swrs_pkg::AW'(1);
          hi_next = hi - swrs_pkg::AW'(1);
        end
      end
    end
  end

  // outputs
  always_comb begin
    ram.rd_addr = lo;
    ram.wr_en   = 1'b0;
    ram.wr_addr = lo;
    ram.wr_data = rd_data;
    case (state)
      swrs_pkg::W_RD0: ram.rd_addr = lo;
      swrs_pkg::W_RD1: ram.rd_addr = hi;
      swrs_pkg::W_CMP: begin
        ram.wr_en   = do_swap;
        ram.wr_addr = lo;
        ram.wr_data = rd_data;
      end
      swrs_pkg::W_WR1: begin
        ram.wr_en   = 1'b1;
        ram.wr_addr = hi;
        ram.wr_data = word_a;
      end
      default: ram.rd_addr = lo;
    endcase
    done = pair_end && finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= swrs_pkg::W_IDLE;
      swapped <= 1'b0;
    end else begin
      state   <= state_next;
      swapped <= swapped_next;
    end
    sort <= sort_next;
    lo   <= lo_next;
    hi   <= hi_next;
    last <= last_next;
    if (state == swrs_pkg::W_RD1) begin
      word_a <= rd_data;
    end
  end

endmodule

`default_nettype wire
